### src/ripc_pkg.sv
`timescale 1ns / 1ps
// Shared codes and the result record for the rendezvous IPC engine.
// No dependencies.
package ripc_pkg;

    // Request operations
    localparam logic [1:0] OP_SEND    = 2'd0;
    localparam logic [1:0] OP_RECV    = 2'd1;
    localparam logic [1:0] OP_NOTIFY  = 2'd2;
    localparam logic [1:0] OP_INVALID = 2'd3;

    // Peer kinds, also used as the stored receive filter kind
    localparam logic [1:0] KIND_SPEC    = 2'd0;
    localparam logic [1:0] KIND_ANY     = 2'd1;
    localparam logic [1:0] KIND_INTR    = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    // Result status codes
    localparam logic [2:0] STAT_DELIV    = 3'd0;
    localparam logic [2:0] STAT_BLOCK    = 3'd1;
    localparam logic [2:0] STAT_INTDEL   = 3'd2;
    localparam logic [2:0] STAT_INTPEND  = 3'd3;
    localparam logic [2:0] STAT_DEADLOCK = 3'd4;
    localparam logic [2:0] STAT_BAD      = 3'd5;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  from_pid;
        logic [4:0]  to_pid;
        logic [31:0] from_handle;
        logic [31:0] to_handle;
        logic [4:0]  woken_pid;
    } res_t;

endpackage

### src/rendezvous_ipc_engine.sv
`timescale 1ns / 1ps
// Rendezvous IPC engine: sequencer around one per-process record memory.
// Depends on ripc_pkg.
//
// The engine serves one request at a time. All per-process state (flags, send
// target, receive filter, buffer handle, queue head/tail and next link) lives
// in a single record memory with one registered read port and one
// write port; a valid bit per entry makes every record read as zero after
// reset, so no clearing pass is needed. A send walks the deadlock chain and a
// specific receive searches the queue for the sender's predecessor; the walk
// cost comes from the single memory read port: each walk step is one record read.
// Writes of the up to three changed records are made at the end, one per
// cycle. The next request is taken while the previous result still waits.
module rendezvous_ipc_engine
    import ripc_pkg::*;
#(
    parameter int NUM_PROCS   = 32,
    parameter int HANDLE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // caller[4:0], peer[9:5], msg_handle[41:10], zero pad
    input  logic [3:0]  s_tuser,   // op[1:0], peer_kind[3:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // from_pid, to_pid, from_handle, to_handle, woken_pid, pad
    output logic [2:0]  m_tuser    // status[2:0]
);

    localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int CW = $clog2(NUM_PROCS + 1);
    localparam int HW = HANDLE_BITS;

    typedef struct packed {
        logic          sending;
        logic          receiving;
        logic [PW-1:0] target;
        logic [1:0]    fkind;
        logic [PW-1:0] fpid;
        logic          intp;
        logic [HW-1:0] handle;
        logic [PW-1:0] qhead;
        logic [PW-1:0] qtail;
        logic          qne;
        logic [PW:0]   link;
    } rec_t;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_FETCH  = 12'b000000000010,
        S_CALLER = 12'b000000000100,
        S_CHAIN  = 12'b000000001000,
        S_CHAINW = 12'b000000010000,
        S_PEER   = 12'b000000100000,
        S_TAIL   = 12'b000001000000,
        S_HEAD   = 12'b000010000000,
        S_PRED   = 12'b000100000000,
        S_PREDW  = 12'b001000000000,
        S_WRITE  = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } state_t;

    // Control registers
    state_t         state_reg, state_next;
    logic           mv_reg, mv_next;
    logic [2:0]     slot_v_reg, slot_v_next;
    logic [NUM_PROCS-1:0] vld_reg;

    // Payload registers
    logic [1:0]     op_reg, op_next;
    logic [4:0]     caller_reg, caller_next;
    logic [4:0]     peer_reg, peer_next;
    logic [1:0]     kind_reg, kind_next;
    logic [HW-1:0]  h_reg, h_next;
    rec_t           rc_reg, rc_next;
    rec_t           rp_reg, rp_next;
    rec_t           prev_rec_reg, prev_rec_next;
    logic [PW-1:0]  prev_reg, prev_next;
    logic           pv_reg, pv_next;
    logic [PW-1:0]  p_reg, p_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    res_t           res_reg, res_next;
    res_t           out_reg, out_next;
    logic [PW-1:0]  slot_a_reg [3];
    logic [PW-1:0]  slot_a_next [3];
    rec_t           slot_d_reg [3];
    rec_t           slot_d_next [3];

    // Record memory
    rec_t           mem [NUM_PROCS];
    rec_t           rdata_reg;
    logic           rvld_reg;
    logic           rd_en;
    logic [PW-1:0]  rd_addr;
    logic           we;
    logic [PW-1:0]  waddr;
    rec_t           wdata;
    rec_t           rd;

    logic [PW-1:0]  cpid;
    logic [PW-1:0]  ppid;
    logic           cnt_full;

    assign rd       = rvld_reg ? rdata_reg : '0;
    assign cpid     = PW'(caller_reg);
    assign ppid     = PW'(peer_reg);
    assign cnt_full = (cnt_reg == CW'(NUM_PROCS));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {1'b0, out_reg.woken_pid, out_reg.to_handle, out_reg.from_handle,
                       out_reg.to_pid, out_reg.from_pid};

    // Sequence one request through reads, decisions and write-back
    always_comb
    begin
        rec_t tmp;
        rec_t tmp2;
        logic [PW:0] nx;

        state_next    = state_reg;
        mv_next       = mv_reg;
        slot_v_next   = slot_v_reg;
        op_next       = op_reg;
        caller_next   = caller_reg;
        peer_next     = peer_reg;
        kind_next     = kind_reg;
        h_next        = h_reg;
        rc_next       = rc_reg;
        rp_next       = rp_reg;
        prev_rec_next = prev_rec_reg;
        prev_next     = prev_reg;
        pv_next       = pv_reg;
        p_next        = p_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        for (int i = 0; i < 3; i++)
        begin
            slot_a_next[i] = slot_a_reg[i];
            slot_d_next[i] = slot_d_reg[i];
        end
        rd_en   = 1'b0;
        rd_addr = '0;
        we      = 1'b0;
        waddr   = '0;
        wdata   = '0;
        tmp     = '0;
        tmp2    = '0;
        nx      = '0;

        // Drop the result once taken
        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_tuser[1:0];
                    kind_next   = s_tuser[3:2];
                    caller_next = s_tdata[4:0];
                    peer_next   = s_tdata[9:5];
                    h_next      = HW'(s_tdata[41:10]);
                    slot_v_next = '0;
                    res_next    = '0;
                    state_next  = S_FETCH;
                end
            end

            S_FETCH:
            begin
                if (op_reg == OP_INVALID || 32'(caller_reg) >= NUM_PROCS)
                begin
                    res_next.status = STAT_BAD;
                    state_next      = S_OUT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cpid;
                    state_next = S_CALLER;
                end
            end

            S_CALLER:
            begin
                rc_next = rd;
                tmp     = rd;
                if (op_reg == OP_NOTIFY)
                begin
                    if (rd.receiving && (rd.fkind == KIND_ANY || rd.fkind == KIND_INTR))
                    begin
                        tmp.receiving      = 1'b0;
                        tmp.fkind          = KIND_SPEC;
                        tmp.fpid           = '0;
                        tmp.handle         = '0;
                        tmp.intp           = 1'b0;
                        res_next.status    = STAT_INTDEL;
                        res_next.to_pid    = caller_reg;
                        res_next.to_handle = 32'(rd.handle);
                        res_next.woken_pid = caller_reg;
                    end
                    else
                    begin
                        tmp.intp        = 1'b1;
                        res_next.status = STAT_INTPEND;
                        res_next.to_pid = caller_reg;
                    end
                    slot_v_next[0] = 1'b1;
                    slot_a_next[0] = cpid;
                    slot_d_next[0] = tmp;
                    state_next     = S_WRITE;
                end
                else if (kind_reg == KIND_INVALID ||
                         (kind_reg == KIND_SPEC &&
                          (32'(peer_reg) >= NUM_PROCS || peer_reg == caller_reg)) ||
                         rd.sending || rd.receiving ||
                         (op_reg == OP_SEND && kind_reg != KIND_SPEC))
                begin
                    res_next.status = STAT_BAD;
                    state_next      = S_OUT;
                end
                else if (op_reg == OP_SEND)
                begin
                    p_next     = ppid;
                    cnt_next   = '0;
                    state_next = S_CHAIN;
                end
                else if (rd.intp && kind_reg != KIND_SPEC)
                begin
                    tmp.intp           = 1'b0;
                    slot_v_next[0]     = 1'b1;
                    slot_a_next[0]     = cpid;
                    slot_d_next[0]     = tmp;
                    res_next.status    = STAT_INTDEL;
                    res_next.to_pid    = caller_reg;
                    res_next.to_handle = 32'(h_reg);
                    state_next         = S_WRITE;
                end
                else if (kind_reg == KIND_ANY && rd.qne)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = rd.qhead;
                    state_next = S_HEAD;
                end
                else if (kind_reg == KIND_SPEC)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ppid;
                    state_next = S_PEER;
                end
                else
                begin
                    // Block the receiver on any or interrupt source
                    tmp.receiving   = 1'b1;
                    tmp.fkind       = kind_reg;
                    tmp.fpid        = '0;
                    tmp.handle      = h_reg;
                    slot_v_next[0]  = 1'b1;
                    slot_a_next[0]  = cpid;
                    slot_d_next[0]  = tmp;
                    res_next.status = STAT_BLOCK;
                    state_next      = S_WRITE;
                end
            end

            S_CHAIN:
            begin
                rd_en = 1'b1;
                if (cnt_full)
                begin
                    rd_addr    = ppid;
                    state_next = S_PEER;
                end
                else
                begin
                    rd_addr    = p_reg;
                    state_next = S_CHAINW;
                end
            end

            S_CHAINW:
            begin
                if (!rd.sending)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ppid;
                    state_next = S_PEER;
                end
                else if (rd.target == cpid)
                begin
                    res_next.status = STAT_DEADLOCK;
                    state_next      = S_OUT;
                end
                else
                begin
                    p_next     = rd.target;
                    cnt_next   = CW'(cnt_reg + 1'b1);
                    state_next = S_CHAIN;
                end
            end

            S_PEER:
            begin
                rp_next = rd;
                if (op_reg == OP_SEND)
                begin
                    if (rd.receiving &&
                        ((rd.fkind == KIND_SPEC && rd.fpid == cpid) || rd.fkind == KIND_ANY))
                    begin
                        tmp                  = rd;
                        tmp.receiving        = 1'b0;
                        tmp.fkind            = KIND_SPEC;
                        tmp.fpid             = '0;
                        tmp.handle           = '0;
                        slot_v_next[2]       = 1'b1;
                        slot_a_next[2]       = ppid;
                        slot_d_next[2]       = tmp;
                        res_next.status      = STAT_DELIV;
                        res_next.from_pid    = caller_reg;
                        res_next.to_pid      = peer_reg;
                        res_next.from_handle = 32'(h_reg);
                        res_next.to_handle   = 32'(rd.handle);
                        res_next.woken_pid   = peer_reg;
                        state_next           = S_WRITE;
                    end
                    else
                    begin
                        // Block the sender and append it to the peer queue
                        tmp             = rc_reg;
                        tmp.sending     = 1'b1;
                        tmp.target      = ppid;
                        tmp.handle      = h_reg;
                        tmp.link        = '0;
                        slot_v_next[0]  = 1'b1;
                        slot_a_next[0]  = cpid;
                        slot_d_next[0]  = tmp;
                        res_next.status = STAT_BLOCK;
                        if (rd.qne)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = rd.qtail;
                            state_next = S_TAIL;
                        end
                        else
                        begin
                            tmp2           = rd;
                            tmp2.qhead     = cpid;
                            tmp2.qtail     = cpid;
                            tmp2.qne       = 1'b1;
                            slot_v_next[2] = 1'b1;
                            slot_a_next[2] = ppid;
                            slot_d_next[2] = tmp2;
                            state_next     = S_WRITE;
                        end
                    end
                end
                else if (rd.sending && rd.target == cpid)
                begin
                    p_next     = rc_reg.qhead;
                    cnt_next   = '0;
                    pv_next    = 1'b0;
                    state_next = S_PRED;
                end
                else
                begin
                    // Block the receiver on a specific source
                    tmp             = rc_reg;
                    tmp.receiving   = 1'b1;
                    tmp.fkind       = KIND_SPEC;
                    tmp.fpid        = ppid;
                    tmp.handle      = h_reg;
                    slot_v_next[0]  = 1'b1;
                    slot_a_next[0]  = cpid;
                    slot_d_next[0]  = tmp;
                    res_next.status = STAT_BLOCK;
                    state_next      = S_WRITE;
                end
            end

            S_TAIL:
            begin
                tmp            = rd;
                tmp.link       = (PW + 1)'(cpid) + 1'b1;
                slot_v_next[1] = 1'b1;
                slot_a_next[1] = rp_reg.qtail;
                slot_d_next[1] = tmp;
                tmp2           = rp_reg;
                tmp2.qtail     = cpid;
                slot_v_next[2] = 1'b1;
                slot_a_next[2] = ppid;
                slot_d_next[2] = tmp2;
                state_next     = S_WRITE;
            end

            S_HEAD:
            begin
                tmp = rc_reg;
                if (rd.link == '0)
                begin
                    tmp.qne   = 1'b0;
                    tmp.qhead = '0;
                    tmp.qtail = '0;
                end
                else
                begin
                    tmp.qhead = PW'(rd.link - 1'b1);
                end
                slot_v_next[0]       = 1'b1;
                slot_a_next[0]       = cpid;
                slot_d_next[0]       = tmp;
                tmp2                 = rd;
                tmp2.link            = '0;
                tmp2.sending         = 1'b0;
                tmp2.target          = '0;
                tmp2.handle          = '0;
                slot_v_next[1]       = 1'b1;
                slot_a_next[1]       = rc_reg.qhead;
                slot_d_next[1]       = tmp2;
                res_next.status      = STAT_DELIV;
                res_next.from_pid    = 5'(rc_reg.qhead);
                res_next.to_pid      = caller_reg;
                res_next.from_handle = 32'(rd.handle);
                res_next.to_handle   = 32'(h_reg);
                res_next.woken_pid   = 5'(rc_reg.qhead);
                state_next           = S_WRITE;
            end

            S_PRED:
            begin
                if (cnt_full || !rc_reg.qne)
                begin
                    res_next.status = STAT_BAD;
                    state_next      = S_OUT;
                end
                else if (p_reg == ppid)
                begin
                    // Unlink the named sender from the caller queue
                    nx  = rp_reg.link;
                    tmp = rc_reg;
                    if (!pv_reg)
                    begin
                        if (nx == '0)
                        begin
                            tmp.qne   = 1'b0;
                            tmp.qhead = '0;
                            tmp.qtail = '0;
                        end
                        else
                        begin
                            tmp.qhead = PW'(nx - 1'b1);
                        end
                    end
                    else
                    begin
                        tmp2           = prev_rec_reg;
                        tmp2.link      = nx;
                        slot_v_next[1] = 1'b1;
                        slot_a_next[1] = prev_reg;
                        slot_d_next[1] = tmp2;
                        if (nx == '0)
                        begin
                            tmp.qtail = prev_reg;
                        end
                    end
                    slot_v_next[0]       = 1'b1;
                    slot_a_next[0]       = cpid;
                    slot_d_next[0]       = tmp;
                    tmp2                 = rp_reg;
                    tmp2.link            = '0;
                    tmp2.sending         = 1'b0;
                    tmp2.target          = '0;
                    tmp2.handle          = '0;
                    slot_v_next[2]       = 1'b1;
                    slot_a_next[2]       = ppid;
                    slot_d_next[2]       = tmp2;
                    res_next.status      = STAT_DELIV;
                    res_next.from_pid    = peer_reg;
                    res_next.to_pid      = caller_reg;
                    res_next.from_handle = 32'(rp_reg.handle);
                    res_next.to_handle   = 32'(h_reg);
                    res_next.woken_pid   = peer_reg;
                    state_next           = S_WRITE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = p_reg;
                    state_next = S_PREDW;
                end
            end

            S_PREDW:
            begin
                prev_next     = p_reg;
                prev_rec_next = rd;
                pv_next       = 1'b1;
                cnt_next      = CW'(cnt_reg + 1'b1);
                if (rd.link == '0)
                begin
                    res_next.status = STAT_BAD;
                    state_next      = S_OUT;
                end
                else
                begin
                    p_next     = PW'(rd.link - 1'b1);
                    state_next = S_PRED;
                end
            end

            S_WRITE:
            begin
                // Drain one changed record per cycle
                if (slot_v_reg[0])
                begin
                    we             = 1'b1;
                    waddr          = slot_a_reg[0];
                    wdata          = slot_d_reg[0];
                    slot_v_next[0] = 1'b0;
                end
                else if (slot_v_reg[1])
                begin
                    we             = 1'b1;
                    waddr          = slot_a_reg[1];
                    wdata          = slot_d_reg[1];
                    slot_v_next[1] = 1'b0;
                end
                else if (slot_v_reg[2])
                begin
                    we             = 1'b1;
                    waddr          = slot_a_reg[2];
                    wdata          = slot_d_reg[2];
                    slot_v_next[2] = 1'b0;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!mv_reg || m_tready)
                begin
                    out_next   = res_reg;
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mv_reg     <= 1'b0;
            slot_v_reg <= '0;
            vld_reg    <= '0;
            rvld_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mv_reg     <= mv_next;
            slot_v_reg <= slot_v_next;
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Advance payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        caller_reg   <= caller_next;
        peer_reg     <= peer_next;
        kind_reg     <= kind_next;
        h_reg        <= h_next;
        rc_reg       <= rc_next;
        rp_reg       <= rp_next;
        prev_rec_reg <= prev_rec_next;
        prev_reg     <= prev_next;
        pv_reg       <= pv_next;
        p_reg        <= p_next;
        cnt_reg      <= cnt_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        for (int i = 0; i < 3; i++)
        begin
            slot_a_reg[i] <= slot_a_next[i];
            slot_d_reg[i] <= slot_d_next[i];
        end
    end

    // Record memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // A failed request leaves no pending record write
    a_no_write_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (res_reg.status == STAT_BAD ||
                                res_reg.status == STAT_DEADLOCK)) |-> (slot_v_reg == '0))
        else $error("record write pending on a failed request");

    // Walk counters stay within the process count
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHAIN || state_reg == S_PRED) |-> (32'(cnt_reg) <= NUM_PROCS))
        else $error("walk counter beyond process count");

    // A new result appears only out of the output state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mv_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

    // An accepted request starts with its lookup
    a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_FETCH))
        else $error("accepted request did not start lookup");

    // The memory is written only while draining records
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == S_WRITE && slot_v_reg != '0))
        else $error("record write outside drain phase");

endmodule
